FILE: rtl/core/rsp_pkg.sv
`default_nettype none
package rsp_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam int CNT_W   = 31;
    localparam int DEPTH_W = 5;
    localparam int TDATA_W = 56;
    localparam int TUSER_W = 5;

    // event kinds
    localparam logic [2:0] EV_PAYLOAD = 3'd0;
    localparam logic [2:0] EV_DONE    = 3'd1;
    localparam logic [2:0] EV_OPEN    = 3'd2;
    localparam logic [2:0] EV_NULL    = 3'd3;
    localparam logic [2:0] EV_EMPTY   = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;

    // value types
    localparam logic [1:0] VT_SIMPLE = 2'd0;
    localparam logic [1:0] VT_INT    = 2'd1;
    localparam logic [1:0] VT_BULK   = 2'd2;
    localparam logic [1:0] VT_ARRAY  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TYPE  = 2'd1;
    localparam logic [1:0] ERR_NUM   = 2'd2;
    localparam logic [1:0] ERR_LIMIT = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAX_BULK  = 1'b0;
    localparam logic CFG_MAX_ARRAY = 1'b1;

    localparam logic [CNT_W-1:0] MAX_BULK_RST  = 31'd536870912;
    localparam logic [CNT_W-1:0] MAX_ARRAY_RST = 31'd1048576;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [31:0] NUM_SAT = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         vtype;
        logic [7:0]         pbyte;
        logic [CNT_W-1:0]   count;
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] closed;
        logic               done;
        logic [1:0]         err;
        logic               last;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] n_now;
        logic [1:0] n_held;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/rsp_ctrl.sv
`default_nettype none
module rsp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  rsp_pkg::dp_stat_t       stat,
    output rsp_pkg::ctrl_cmd_t      cmd
);
    import rsp_pkg::*;

    typedef enum logic [1:0] {ST_RX, ST_EXEC, ST_TX0, ST_TX1} state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_RX:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    if (stat.n_now == 2'd0)
                    begin
                        state_reg    <= ST_RX;
                        in_ready_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg     <= ST_TX0;
                        out_valid_reg <= 1'b1;
                        sel_reg       <= 1'b0;
                    end
                end
                ST_TX0:
                begin
                    if (out_ready)
                    begin
                        if (stat.n_held == 2'd2)
                        begin
                            state_reg <= ST_TX1;
                            sel_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg     <= ST_RX;
                            out_valid_reg <= 1'b0;
                            in_ready_reg  <= 1'b1;
                        end
                    end
                end
                ST_TX1:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= ST_RX;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_RX;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
    assign cmd.load  = in_ready_reg && in_valid;
    assign cmd.exec  = (state_reg == ST_EXEC);
    assign cmd.sel   = sel_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rsp_dp.sv
`default_nettype none
module rsp_dp #(
    parameter int MAX_DEPTH = rsp_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [rsp_pkg::CNT_W-1:0]  cfg_data,
    input  wire logic [7:0]                 rx_byte,
    input  rsp_pkg::ctrl_cmd_t              cmd,
    output rsp_pkg::dp_stat_t               stat,
    output rsp_pkg::result_t                res
);
    import rsp_pkg::*;

    localparam int SPW = $clog2(MAX_DEPTH + 1);
    localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [2:0] {PH_IDLE, PH_HDR, PH_LINE, PH_BODY, PH_TRAIL} phase_t;

    logic [CNT_W-1:0] max_bulk_reg, max_array_reg;
    logic [7:0]       byte_reg;
    phase_t           phase_reg, phase_next;
    logic [1:0]       type_reg, type_next;
    logic [31:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next, seen_reg, seen_next;
    logic             ended_reg, ended_next, cr_reg, cr_next;
    logic [CNT_W-1:0] bulk_reg, bulk_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [CNT_W-1:0] stk_reg [MAX_DEPTH];
    logic             one_reg [MAX_DEPTH];
    result_t          slot0_reg, slot1_reg, r0, r1;
    logic [1:0]       nres_reg, n_c;

    logic             stk_we;
    logic [IW-1:0]    stk_wa;
    logic [CNT_W-1:0] stk_wd, top_val;
    logic [SPW-1:0]   newsp, closed_k;
    logic [35:0]      acc_mul;
    logic             is_digit;

    function automatic result_t mk(input logic [2:0] kind, input logic [1:0] vt,
                                   input logic [7:0] pb, input logic [CNT_W-1:0] cnt,
                                   input logic [SPW-1:0] d, input logic [SPW-1:0] k,
                                   input logic dn, input logic [1:0] e);
        result_t r;
        r.kind   = kind;
        r.vtype  = vt;
        r.pbyte  = pb;
        r.count  = cnt;
        r.depth  = DEPTH_W'(d);
        r.closed = DEPTH_W'(k);
        r.done   = dn;
        r.err    = e;
        r.last   = 1'b0;
        return r;
    endfunction

    // highest level still expecting more than one element; all above it close
    always_comb
    begin
        newsp = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if ((SPW'(i) < sp_reg) && !one_reg[i])
                newsp = SPW'(i + 1);
        end
    end
    assign closed_k = sp_reg - newsp;
    assign top_val  = stk_reg[IW'(newsp - SPW'(1))];

    assign is_digit = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign acc_mul  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {28'b0, byte_reg - CH_ZERO};

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        ended_next = ended_reg;
        cr_next    = cr_reg;
        bulk_next  = bulk_reg;
        sp_next    = sp_reg;
        stk_we     = 1'b0;
        stk_wa     = IW'(newsp - SPW'(1));
        stk_wd     = top_val - CNT_W'(1);
        n_c        = 2'd0;
        r0         = '0;
        r1         = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                acc_next   = '0;
                neg_next   = 1'b0;
                seen_next  = 1'b0;
                ended_next = 1'b0;
                cr_next    = 1'b0;
                priority if (byte_reg == CH_STAR)
                begin
                    type_next = VT_ARRAY; phase_next = PH_HDR;
                end
                else if (byte_reg == CH_DOLLAR)
                begin
                    type_next = VT_BULK; phase_next = PH_HDR;
                end
                else if (byte_reg == CH_PLUS)
                begin
                    type_next = VT_SIMPLE; phase_next = PH_LINE;
                end
                else if (byte_reg == CH_COLON)
                begin
                    type_next = VT_INT; phase_next = PH_LINE;
                end
                else
                begin
                    r0 = mk(EV_ERROR, VT_SIMPLE, '0, '0, sp_reg, '0, 1'b0, ERR_TYPE);
                    n_c = 2'd1;
                    type_next = VT_SIMPLE;
                    bulk_next = '0;
                    sp_next   = '0;
                end
            end
            PH_HDR:
            begin
                if (cr_reg && byte_reg == CH_LF)
                begin
                    cr_next = 1'b0;
                    n_c     = 2'd1;
                    phase_next = PH_IDLE;
                    priority if (!seen_reg)
                    begin
                        r0 = mk(EV_ERROR, type_reg, '0, '0, sp_reg, '0, 1'b0, ERR_NUM);
                    end
                    else if (neg_reg && acc_reg != 32'd0)
                    begin
                        if (type_reg == VT_BULK || acc_reg == 32'd1)
                        begin
                            r0 = mk(EV_NULL, type_reg, '0, '0, sp_reg, closed_k,
                                    (closed_k == sp_reg), ERR_NONE);
                            sp_next = newsp;
                            stk_we  = (newsp != '0);
                        end
                        else
                            r0 = mk(EV_ERROR, type_reg, '0, '0, sp_reg, '0, 1'b0, ERR_NUM);
                    end
                    else if (type_reg == VT_ARRAY)
                    begin
                        priority if (acc_reg == 32'd0)
                        begin
                            r0 = mk(EV_EMPTY, VT_ARRAY, '0, '0, sp_reg, closed_k,
                                    (closed_k == sp_reg), ERR_NONE);
                            sp_next = newsp;
                            stk_we  = (newsp != '0);
                        end
                        else if (acc_reg > {1'b0, max_array_reg}
                                 || sp_reg >= SPW'(MAX_DEPTH))
                        begin
                            r0 = mk(EV_ERROR, VT_ARRAY, '0, '0, sp_reg, '0, 1'b0, ERR_LIMIT);
                        end
                        else
                        begin
                            r0 = mk(EV_OPEN, VT_ARRAY, '0, acc_reg[CNT_W-1:0], sp_reg, '0,
                                    1'b0, ERR_NONE);
                            stk_we  = 1'b1;
                            stk_wa  = IW'(sp_reg);
                            stk_wd  = acc_reg[CNT_W-1:0];
                            sp_next = sp_reg + SPW'(1);
                        end
                    end
                    else if (acc_reg > {1'b0, max_bulk_reg})
                    begin
                        r0 = mk(EV_ERROR, VT_BULK, '0, '0, sp_reg, '0, 1'b0, ERR_LIMIT);
                    end
                    else
                    begin
                        n_c = 2'd0;
                        if (acc_reg == 32'd0)
                        begin
                            phase_next = PH_TRAIL; bulk_next = CNT_W'(2);
                        end
                        else
                        begin
                            phase_next = PH_BODY; bulk_next = acc_reg[CNT_W-1:0];
                        end
                    end
                    // every failure drops back to an empty parser
                    if (r0.kind == EV_ERROR)
                    begin
                        type_next = VT_SIMPLE;
                        acc_next = '0; neg_next = 1'b0; seen_next = 1'b0; ended_next = 1'b0;
                        bulk_next = '0;
                        sp_next   = '0;
                    end
                end
                else
                begin
                    if (cr_reg)
                        ended_next = 1'b1;
                    cr_next = (byte_reg == CH_CR);
                    if (!cr_reg && byte_reg != CH_CR && !ended_reg)
                    begin
                        priority if (is_digit)
                        begin
                            acc_next  = (acc_mul > {4'b0, NUM_SAT}) ? NUM_SAT : acc_mul[31:0];
                            seen_next = 1'b1;
                        end
                        else if (byte_reg == CH_MINUS && !seen_reg && !neg_reg)
                            neg_next = 1'b1;
                        else
                            ended_next = 1'b1;
                    end
                end
            end
            PH_LINE:
            begin
                cr_next = 1'b0;
                if (cr_reg && byte_reg == CH_LF)
                begin
                    r0 = mk(EV_DONE, type_reg, '0, '0, sp_reg, closed_k,
                            (closed_k == sp_reg), ERR_NONE);
                    n_c        = 2'd1;
                    phase_next = PH_IDLE;
                    sp_next    = newsp;
                    stk_we     = (newsp != '0);
                end
                else
                begin
                    // hold back a CR until the next byte shows whether LF follows
                    if (cr_reg)
                    begin
                        r0  = mk(EV_PAYLOAD, type_reg, CH_CR, '0, sp_reg, '0, 1'b0, ERR_NONE);
                        n_c = 2'd1;
                    end
                    if (byte_reg == CH_CR)
                        cr_next = 1'b1;
                    else if (cr_reg)
                    begin
                        r1  = mk(EV_PAYLOAD, type_reg, byte_reg, '0, sp_reg, '0, 1'b0, ERR_NONE);
                        n_c = 2'd2;
                    end
                    else
                    begin
                        r0  = mk(EV_PAYLOAD, type_reg, byte_reg, '0, sp_reg, '0, 1'b0, ERR_NONE);
                        n_c = 2'd1;
                    end
                end
            end
            PH_BODY:
            begin
                r0  = mk(EV_PAYLOAD, VT_BULK, byte_reg, acc_reg[CNT_W-1:0], sp_reg, '0,
                         1'b0, ERR_NONE);
                n_c = 2'd1;
                if (bulk_reg == CNT_W'(1))
                begin
                    phase_next = PH_TRAIL; bulk_next = CNT_W'(2);
                end
                else
                    bulk_next = bulk_reg - CNT_W'(1);
            end
            PH_TRAIL:
            begin
                if (bulk_reg != '0)
                    bulk_next = bulk_reg - CNT_W'(1);
                if (bulk_reg <= CNT_W'(1))
                begin
                    r0 = mk(EV_DONE, VT_BULK, '0, acc_reg[CNT_W-1:0], sp_reg, closed_k,
                            (closed_k == sp_reg), ERR_NONE);
                    n_c        = 2'd1;
                    phase_next = PH_IDLE;
                    sp_next    = newsp;
                    stk_we     = (newsp != '0);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        r0.last = (n_c == 2'd1);
        r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bulk_reg  <= MAX_BULK_RST;
            max_array_reg <= MAX_ARRAY_RST;
            phase_reg     <= PH_IDLE;
            type_reg      <= VT_SIMPLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            ended_reg     <= 1'b0;
            cr_reg        <= 1'b0;
            bulk_reg      <= '0;
            sp_reg        <= '0;
            nres_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_BULK:  max_bulk_reg  <= cfg_data;
                    CFG_MAX_ARRAY: max_array_reg <= cfg_data;
                    default:       max_bulk_reg  <= max_bulk_reg;
                endcase
            end
            if (cmd.exec)
            begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                seen_reg  <= seen_next;
                ended_reg <= ended_next;
                cr_reg    <= cr_next;
                bulk_reg  <= bulk_next;
                sp_reg    <= sp_next;
                nres_reg  <= n_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            byte_reg <= rx_byte;
        if (cmd.exec)
        begin
            slot0_reg <= r0;
            slot1_reg <= r1;
        end
        if (cmd.exec && stk_we)
        begin
            stk_reg[stk_wa] <= stk_wd;
            one_reg[stk_wa] <= (stk_wd == CNT_W'(1));
        end
    end

    assign stat.n_now  = n_c;
    assign stat.n_held = nres_reg;
    assign res         = cmd.sel ? slot1_reg : slot0_reg;

endmodule
`default_nettype wire

FILE: rtl/core/resp_stream_parser_core.sv
`default_nettype none
// Channel   Dir  Handshake                 Contents
// s_*       in   s_tvalid / s_tready       one stream byte per transaction
// m_*       out  m_tvalid / m_tready       one parse event per transaction
// cfg_*     in   cfg_we (no wait)          limit registers
//
// A byte is captured, then goes through the parse step in the datapath, then each
// event it causes (0 to 2 events) is drained from the two-entry result buffer.
// Closing of finished arrays is resolved in the parse step from per-level
// count-equals-one flags.
// Reset clears the parser to idle with an empty stack and loads default limits.
// A stalled m_tready holds the current event; no new byte is taken meanwhile.
module resp_stream_parser_core #(
    parameter int MAX_DEPTH = rsp_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] rx_byte
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [7:0] payload_byte, [38:8] element_count, [43:39] nesting_depth,
    // [48:44] arrays_closed, [49] message_done, [51:50] error_code, rest zero
    output logic [rsp_pkg::TDATA_W-1:0]       m_tdata,
    output logic [rsp_pkg::TUSER_W-1:0]       m_tuser,   // [2:0] event_kind, [4:3] value_type
    output logic                              m_tlast,   // last_of_run
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [rsp_pkg::CNT_W-1:0]    cfg_data
);
    import rsp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    result_t   res;

    rsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rsp_dp #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    // pack the event fields, lowest field first
    assign m_tdata = {4'b0, res.err, res.done, res.closed, res.depth, res.count, res.pbyte};
    assign m_tuser = {res.vtype, res.kind};
    assign m_tlast = res.last;

    // one byte in flight: never take a byte while an event is offered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("byte accepted while an event is pending");

    // the parse step follows every accepted byte, so no event is offered then
    a_exec_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("event offered in the parse cycle");

    // a finished message has closed every array that enclosed it
    a_done_closes_all: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[49]) |-> (m_tdata[48:44] == m_tdata[43:39]))
        else $error("message done with arrays left open");

endmodule
`default_nettype wire

FILE: verif/resp_event_checker.sv
`default_nettype none
// Watches the byte and event streams of the parser, predicts every event from
// the accepted bytes and compares it field by field with what comes out.
module resp_event_checker
    import rsp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [TDATA_W-1:0]   m_tdata,
    input  wire logic [TUSER_W-1:0]   m_tuser,
    input  wire logic                 m_tlast,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        pending,
    output int                        events_seen
);

    localparam int PH_IDLE = 0, PH_HDR = 1, PH_LINE = 2, PH_BODY = 3, PH_TRAIL = 4;
    localparam int DEPTH = MAX_DEPTH_DEF;

    result_t expected_events[$];

    logic [CNT_W-1:0] lim_bulk, lim_array;
    int               phase;
    logic [1:0]       cur_type;
    logic [31:0]      accum;
    logic             neg, seen_digit, ended, held_cr;
    logic [31:0]      bulk_left;
    int               sp;
    logic [CNT_W-1:0] open_counts [DEPTH];

    assign pending = expected_events.size();

    function automatic result_t mk(logic [2:0] k, logic [1:0] t, logic [7:0] b,
                                   logic [CNT_W-1:0] c, int d, int cl, logic dn,
                                   logic [1:0] e);
        result_t r;
        r.kind = k; r.vtype = t; r.pbyte = b; r.count = c;
        r.depth = d[DEPTH_W-1:0]; r.closed = cl[DEPTH_W-1:0];
        r.done = dn; r.err = e; r.last = 1'b0;
        return r;
    endfunction

    // Append one predicted event at the back of the queue.
    task automatic expect_event(result_t r);
        expected_events = {expected_events, r};
    endtask

    task automatic clear_number();
        accum = 0; neg = 0; seen_digit = 0; ended = 0; held_cr = 0;
    endtask

    task automatic raise_error(logic [1:0] t, logic [1:0] e);
        expect_event(mk(EV_ERROR, t, 8'd0, '0, sp, 0, 1'b0, e));
        phase = PH_IDLE; cur_type = VT_SIMPLE; clear_number(); bulk_left = 0; sp = 0;
    endtask

    // Close every array that this completion finishes, in one step.
    task automatic finish_value(logic [2:0] k, logic [1:0] t, logic [CNT_W-1:0] c);
        int d, n;
        logic dn;
        d = sp; n = 0; dn = 1'b1;
        if (d > 0) begin
            while (n < d && open_counts[d-1-n] == 1) n++;
            sp = d - n;
            if (sp > 0) open_counts[sp-1] = open_counts[sp-1] - 1;
            dn = (n == d);
        end
        expect_event(mk(k, t, 8'd0, c, d, n, dn, ERR_NONE));
        phase = PH_IDLE;
    endtask

    task automatic number_char(logic [7:0] b);
        logic [35:0] v;
        if (ended) return;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            v = accum * 36'd10 + (b - CH_ZERO);
            accum = (v > NUM_SAT) ? NUM_SAT : v[31:0];
            seen_digit = 1;
        end else if (b == CH_MINUS && !seen_digit && !neg)
            neg = 1;
        else
            ended = 1;
    endtask

    task automatic header_done();
        if (!seen_digit) begin
            raise_error(cur_type, ERR_NUM);
            return;
        end
        if (neg && accum != 0) begin
            if (cur_type == VT_BULK || accum == 1) finish_value(EV_NULL, cur_type, '0);
            else raise_error(cur_type, ERR_NUM);
            return;
        end
        if (cur_type == VT_ARRAY) begin
            if (accum == 0) finish_value(EV_EMPTY, VT_ARRAY, '0);
            else if (accum > lim_array || sp >= DEPTH) raise_error(VT_ARRAY, ERR_LIMIT);
            else begin
                expect_event(mk(EV_OPEN, VT_ARRAY, 8'd0, accum[CNT_W-1:0],
                                sp, 0, 1'b0, ERR_NONE));
                open_counts[sp] = accum[CNT_W-1:0];
                sp++;
                phase = PH_IDLE;
            end
            return;
        end
        if (accum > lim_bulk) begin
            raise_error(VT_BULK, ERR_LIMIT);
            return;
        end
        phase = (accum == 0) ? PH_TRAIL : PH_BODY;
        bulk_left = (accum == 0) ? 32'd2 : accum;
    endtask

    task automatic parse_byte(logic [7:0] b);
        int first;
        first = expected_events.size();
        case (phase)
            PH_HDR: begin
                if (held_cr) begin
                    held_cr = 0;
                    if (b == CH_LF) header_done();
                    else begin
                        number_char(CH_CR);
                        if (b == CH_CR) held_cr = 1; else number_char(b);
                    end
                end else if (b == CH_CR) held_cr = 1;
                else number_char(b);
            end
            PH_LINE: begin
                if (held_cr && b == CH_LF) begin
                    held_cr = 0;
                    finish_value(EV_DONE, cur_type, '0);
                end else begin
                    if (held_cr)
                        expect_event(mk(EV_PAYLOAD, cur_type, CH_CR, '0, sp,
                                        0, 1'b0, ERR_NONE));
                    held_cr = (b == CH_CR);
                    if (b != CH_CR)
                        expect_event(mk(EV_PAYLOAD, cur_type, b, '0, sp,
                                        0, 1'b0, ERR_NONE));
                end
            end
            PH_BODY: begin
                expect_event(mk(EV_PAYLOAD, VT_BULK, b, accum[CNT_W-1:0], sp,
                                0, 1'b0, ERR_NONE));
                bulk_left--;
                if (bulk_left == 0) begin
                    phase = PH_TRAIL; bulk_left = 2;
                end
            end
            PH_TRAIL: begin
                if (bulk_left > 0) bulk_left--;
                if (bulk_left == 0) finish_value(EV_DONE, VT_BULK, accum[CNT_W-1:0]);
            end
            default: begin
                clear_number();
                if (b == CH_STAR) begin cur_type = VT_ARRAY; phase = PH_HDR; end
                else if (b == CH_DOLLAR) begin cur_type = VT_BULK; phase = PH_HDR; end
                else if (b == CH_PLUS) begin cur_type = VT_SIMPLE; phase = PH_LINE; end
                else if (b == CH_COLON) begin cur_type = VT_INT; phase = PH_LINE; end
                else raise_error(VT_SIMPLE, ERR_TYPE);
            end
        endcase
        if (expected_events.size() > first)
            expected_events[expected_events.size()-1].last = 1'b1;
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            lim_bulk = MAX_BULK_RST; lim_array = MAX_ARRAY_RST;
            phase = PH_IDLE; cur_type = VT_SIMPLE; clear_number();
            bulk_left = 0; sp = 0;
            expected_events.delete();
            fail_count = 0; events_seen = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MAX_BULK) lim_bulk = cfg_data;
                else lim_array = cfg_data;
            end
            // Compare first: an event never leaves in the cycle its byte enters.
            if (m_tvalid && m_tready) begin
                events_seen++;
                if (expected_events.size() == 0) begin
                    $error("unexpected event: kind %0d", m_tuser[2:0]);
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.kind, m_tuser[2:0]);
                    check_field("value_type", want.vtype, m_tuser[4:3]);
                    check_field("payload_byte", want.pbyte, m_tdata[7:0]);
                    check_field("element_count", want.count, m_tdata[38:8]);
                    check_field("nesting_depth", want.depth, m_tdata[43:39]);
                    check_field("arrays_closed", want.closed, m_tdata[48:44]);
                    check_field("message_done", want.done, m_tdata[49]);
                    check_field("error_code", want.err, m_tdata[51:50]);
                    check_field("last_of_run", want.last, m_tlast);
                    check_field("tdata_pad", 0, m_tdata[TDATA_W-1:52]);
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata);
        end
    end

endmodule
`default_nettype wire

FILE: verif/resp_stream_parser_core_tb.sv
`default_nettype none
// Drives byte streams into the parser: a directed set of corner cases, then
// mostly well-formed nested messages with random content plus noise, across
// several limit settings and idling phases. The checker does the prediction.
module resp_stream_parser_core_tb;
    import rsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 100;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;
    logic                m_tlast;
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_MAX_BULK;
    logic [CNT_W-1:0]    cfg_data = '0;

    int fail_count, pending, events_seen;
    int bytes_sent = 0;
    int phase_start = 0;
    int cycles = 0;
    int idle_pct = 0;    // sender idle chance, percent
    int stall_pct = 0;   // receiver stall chance, percent
    logic [7:0] wire_bytes[$];   // bytes waiting to be sent

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    resp_stream_parser_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    resp_event_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .events_seen(events_seen)
    );

    // Watchdog: abort on a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall at random at the current rate, updated at the falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Queue one byte at the back of the send queue.
    task automatic put_byte(logic [7:0] b);
        wire_bytes = {wire_bytes, b};
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    // Random header number: mostly small, sometimes signed, odd or long.
    task automatic put_number(int lo, int hi);
        int r;
        r = $urandom_range(99);
        if (r < 85) put_text($sformatf("%0d", $urandom_range(hi, lo)));
        else if (r < 90) put_text("-1");
        else if (r < 93) put_text("-0");
        else if (r < 96) put_text($sformatf("%0d", $urandom_range(9999, 0)));
        else put_text($sformatf("%0dx", $urandom_range(hi, lo)));
        put_crlf();
    endtask

    task automatic put_line_content();
        int n;
        logic [7:0] b;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
        begin
            // any byte but CR; an occasional lone CR mid-line
            b = 8'($urandom_range(255));
            if (b == CH_CR)
                b = 8'hFF;
            if ($urandom_range(15) == 0)
                b = CH_CR;
            put_byte(b);
        end
        put_crlf();
    endtask

    // Build one well-formed value, nesting arrays up to a random depth.
    task automatic put_value(int depth);
        int r, n;
        r = $urandom_range(9);
        if (r < 3 && depth < 17)
        begin
            n = $urandom_range(3);
            put_byte(CH_STAR);
            put_text($sformatf("%0d", n));
            put_crlf();
            for (int i = 0; i < n; i++) put_value(depth + 1);
        end
        else if (r < 6)
        begin
            n = $urandom_range(4);
            put_byte(CH_DOLLAR);
            put_text($sformatf("%0d", n));
            put_crlf();
            for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
            put_crlf();
        end
        else
        begin
            put_byte(r < 8 ? CH_PLUS : CH_COLON);
            put_line_content();
        end
    endtask

    // Drain the byte queue through the slave channel.
    task automatic send_all();
        while (wire_bytes.size() > 0)
        begin
            s_tdata  <= wire_bytes[0];
            s_tvalid <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                void'(wire_bytes.pop_front());
                bytes_sent++;
            end
            @(negedge clk);
        end
        s_tvalid <= 1'b0;
    endtask

    // Pause: wait for every expected event, then let the last byte settle.
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_limit(logic idx, logic [CNT_W-1:0] v);
        drain();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every type, nulls, empty array, signs, lone CR, errors.
        put_text("+OK"); put_crlf();
        put_text(":-42"); put_crlf();
        put_text("+a\rb"); put_crlf();
        put_text("$3"); put_crlf();
        put_byte(8'h00); put_byte(8'hFF); put_byte(8'h78); put_crlf();
        put_text("$0"); put_crlf(); put_crlf();
        put_text("$-5"); put_crlf();
        put_text("*-1"); put_crlf();
        put_text("*0"); put_crlf();
        put_text("*-0"); put_crlf();
        put_text("*-2"); put_crlf();
        put_text("*x"); put_crlf();
        put_text("$--1"); put_crlf();
        put_text("*2\r5"); put_crlf(); put_text("+"); put_crlf(); put_text(":1"); put_crlf();
        put_text("*99999999999"); put_crlf();
        put_text("$+3"); put_crlf();
        put_byte(8'h00); put_byte(8'hFF);
        for (int i = 0; i < 17; i++) put_text("*1\r\n");   // depth overflow
        send_all();

        // Tight limits, including zero, then the extremes.
        set_limit(CFG_MAX_BULK, '0);
        set_limit(CFG_MAX_ARRAY, 31'd1);
        put_text("$1"); put_crlf(); put_text("$0"); put_crlf(); put_crlf();
        put_text("*2"); put_crlf(); put_text("*1"); put_crlf(); put_text("+z"); put_crlf();
        send_all();
        set_limit(CFG_MAX_BULK, 31'h7FFF_FFFF);
        set_limit(CFG_MAX_ARRAY, 31'h7FFF_FFFF);
        // saturated lengths exceed even the largest limits
        put_text("*2147483648"); put_crlf();
        put_text("$2147483648"); put_crlf();
        send_all();

        // Keep limits small for random traffic so oversized headers show up.
        set_limit(CFG_MAX_BULK, 31'd3);
        set_limit(CFG_MAX_ARRAY, 31'd3);

        // Random: five idling phases with a limit change after each.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                3: begin idle_pct = 25; stall_pct = 25; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(9) == 0)
                    put_byte(8'($urandom_range(255)));           // noise
                else if ($urandom_range(19) == 0)
                    put_number(0, 5);                            // header tail alone
                else
                    put_value(0);
                send_all();
            end
            set_limit(ph[0] ? CFG_MAX_ARRAY : CFG_MAX_BULK, CNT_W'($urandom_range(6, 2)));
        end
        stall_pct = 0;
        drain();

        $display("Covered %0d stream bytes and %0d parse events over five idling phases.",
                 bytes_sent, events_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
